/* hdl/assert_macros.svh */
// Assertion macros shared by the slerp RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold whenever the antecedent holds.
`define QS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qs assertion failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define QS_ASSERT_DELAY(lbl, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("qs delayed assertion failed");

`endif

/* hdl/qs_pkg.sv */
// Shared types, constants and the CORDIC arctangent table for the slerp block.
// Depends on nothing; quaternion_slerp and the two CORDIC cells refer to it by scoped names.
package qs_pkg;

    localparam int FRAC_BITS = 14;
    localparam int WF        = 30;
    localparam logic [30:0] ONE_W    = 31'h4000_0000;
    localparam logic [34:0] NEAR_LIM = 35'h0_4000_0000 - 35'd1074;
    localparam logic [14:0] T_ONE    = 15'd16384;
    localparam logic [31:0] W_MAX    = 32'h8000_0000;

    // Side data that rides along the chain next to the arithmetic.
    typedef struct packed {
        logic [3:0][15:0] a;
        logic [3:0][15:0] b;
        logic [30:0]      t30;
        logic [29:0]      mag;
        logic             negate;
        logic             near;
        logic             deg;
    } side_t;

    // atan(2^-i) in Q30.
    function automatic logic [31:0] atan_at(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

/* hdl/quaternion_slerp.sv */
// Quaternion slerp, fully pipelined. Depends on qs_pkg, the four cell modules
// and assert_macros.svh.
//
// Use: drive the two quaternions (Q2.14) and blend_t (16384 = 1.0) and raise
// start for one cycle per word. busy is always low, so a word is taken at
// every edge where start is high: one word per cycle, sustained.
// Each word yields one result word on out_x..out_w, shown for exactly one
// cycle with done high. On its way a word passes the input registers,
// 31 square-root cells, the vectoring CORDIC cells, the angle product
// registers, the three parallel rotation CORDIC lanes, the divider setup
// registers, 33 divider cells and the weight, blend and output registers.
// Results leave in the order words entered. The receiver cannot stall; a
// result is gone after its one cycle.
// Reset clears the valid marks of the chain, so words in flight are dropped;
// the datapath itself needs no reset.
module quaternion_slerp #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] from_x,
    input  logic signed [15:0] from_y,
    input  logic signed [15:0] from_z,
    input  logic signed [15:0] from_w,
    input  logic signed [15:0] to_x,
    input  logic signed [15:0] to_y,
    input  logic signed [15:0] to_z,
    input  logic signed [15:0] to_w,
    input  logic        [14:0] blend_t,
    output logic               done,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic signed [15:0] out_z,
    output logic signed [15:0] out_w
);

    localparam int N   = CORDIC_STEPS;
    localparam int LSQ = 35;
    localparam int LV  = LSQ + N;
    localparam int LA  = LV + 1;
    localparam int LR  = LA + N;
    localparam int LD0 = LR + 1;
    localparam int LQ  = LD0 + 33;
    localparam int LW  = LQ + 1;
    localparam int LC  = LW + 1;
    localparam int LO  = LC + 1;

    logic                  accept;
    logic [LO-1:0]         v_reg;
    qs_pkg::side_t         side_reg [0:LW-1];
    qs_pkg::side_t         side_in;
    qs_pkg::side_t         side_flag;
    qs_pkg::side_t         side_deg;

    logic signed [33:0]    dot_reg;
    logic        [29:0]    mag_reg;
    logic        [59:0]    sq_reg;
    logic        [60:0]    rad_reg;
    logic        [33:0]    dot_abs;
    logic        [14:0]    tq;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Input stage: dot product and clamped t.
    always_comb
    begin
        tq = (blend_t > qs_pkg::T_ONE) ? qs_pkg::T_ONE : blend_t;
        side_in        = '0;
        side_in.a      = {from_w, from_z, from_y, from_x};
        side_in.b      = {to_w, to_z, to_y, to_x};
        side_in.t30    = {tq[14:0], 16'h0000};
        dot_abs        = dot_reg[33] ? 34'(-dot_reg) : dot_reg;
        side_flag        = side_reg[0];
        side_flag.negate = dot_reg[33];
        side_flag.near   = {dot_abs[32:0], 2'b00} >= qs_pkg::NEAR_LIM;
        side_flag.mag    = {dot_abs[27:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        dot_reg <= 34'(from_x * to_x) + 34'(from_y * to_y)
                 + 34'(from_z * to_z) + 34'(from_w * to_w);
        mag_reg <= {dot_abs[27:0], 2'b00};
        sq_reg  <= mag_reg * mag_reg;
        rad_reg <= 61'h1000_0000_0000_0000 - {1'b0, sq_reg};
        side_reg[0] <= side_in;
        side_reg[1] <= side_flag;
    end

    genvar gi;
    genvar gl;

    generate
        for (gi = 2; gi < LW; gi++)
        begin : g_side
            if (gi == LD0 - 1)
            begin : g_deg
                always_ff @(posedge clk)
                begin
                    side_reg[gi] <= side_deg;
                end
            end
            else
            begin : g_copy
                always_ff @(posedge clk)
                begin
                    side_reg[gi] <= side_reg[gi-1];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[LO-2:0], accept};
        end
    end

    // Square root of 1 - dot^2.
    logic [60:0] sv_w [0:31];
    logic [61:0] sr_w [0:31];

    assign sv_w[0] = rad_reg;
    assign sr_w[0] = '0;

    generate
        for (gi = 0; gi < 31; gi++)
        begin : g_sqrt
            qs_sqrt_cell #(.K(30 - gi)) u_cell (
                .clk   (clk),
                .v_in  (sv_w[gi]),
                .r_in  (sr_w[gi]),
                .v_out (sv_w[gi+1]),
                .r_out (sr_w[gi+1])
            );
        end
    endgenerate

    // Vectoring CORDIC gives the angle acos(|dot|).
    logic signed [33:0] vx_w [0:N];
    logic signed [33:0] vy_w [0:N];
    logic signed [33:0] vz_w [0:N];

    assign vx_w[0] = {4'b0000, side_reg[LSQ-1].mag};
    assign vy_w[0] = {3'b000, sr_w[31][30:0]};
    assign vz_w[0] = '0;

    generate
        for (gi = 0; gi < N; gi++)
        begin : g_vec
            qs_vec_cell #(.I(gi)) u_cell (
                .clk   (clk),
                .x_in  (vx_w[gi]),
                .y_in  (vy_w[gi]),
                .z_in  (vz_w[gi]),
                .x_out (vx_w[gi+1]),
                .y_out (vy_w[gi+1]),
                .z_out (vz_w[gi+1])
            );
        end
    endgenerate

    // Angle products (1-t)*o and t*o.
    logic signed [32:0] ang;
    logic        [30:0] omt;
    logic signed [64:0] p_a0;
    logic signed [64:0] p_a1;
    logic signed [32:0] ang_reg [0:2];

    always_comb
    begin
        ang  = vz_w[N][32:0];
        omt  = qs_pkg::ONE_W - side_reg[LV-1].t30;
        p_a0 = $signed({1'b0, omt}) * ang;
        p_a1 = $signed({1'b0, side_reg[LV-1].t30}) * ang;
    end

    always_ff @(posedge clk)
    begin
        ang_reg[0] <= ang;
        ang_reg[1] <= p_a0[62:30];
        ang_reg[2] <= p_a1[62:30];
    end

    // Three rotation lanes: sin(o), sin((1-t)o), sin(t*o).
    logic signed [33:0] rx_w [0:2][0:N];
    logic signed [33:0] ry_w [0:2][0:N];
    logic signed [33:0] rz_w [0:2][0:N];

    generate
        for (gl = 0; gl < 3; gl++)
        begin : g_lane
            assign rx_w[gl][0] = 34'(qs_pkg::ONE_W);
            assign ry_w[gl][0] = '0;
            assign rz_w[gl][0] = {ang_reg[gl][32], ang_reg[gl]};
            for (gi = 0; gi < N; gi++)
            begin : g_rot
                qs_rot_cell #(.I(gi)) u_cell (
                    .clk   (clk),
                    .x_in  (rx_w[gl][gi]),
                    .y_in  (ry_w[gl][gi]),
                    .z_in  (rz_w[gl][gi]),
                    .x_out (rx_w[gl][gi+1]),
                    .y_out (ry_w[gl][gi+1]),
                    .z_out (rz_w[gl][gi+1])
                );
            end
        end
    endgenerate

    // Divider setup: clamp the numerator sines at zero and flag overflow.
    logic [31:0] num [0:1];
    logic [31:0] den;

    always_comb
    begin
        den = ry_w[0][N][31:0];
        for (int k = 0; k < 2; k++)
        begin
            num[k] = ry_w[k+1][N][33] ? 32'h0 : ry_w[k+1][N][31:0];
        end
        side_deg     = side_reg[LD0-2];
        side_deg.deg = (ry_w[0][N] <= 0);
    end

    logic [31:0] dd_w   [0:1][0:33];
    logic [61:0] dr_w   [0:1][0:33];
    logic [32:0] dq_w   [0:1][0:33];
    logic        dovf_w [0:1][0:33];
    logic [31:0] dden_reg [0:1];
    logic [61:0] dr_reg   [0:1];
    logic        dovf_reg [0:1];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 2; k++)
        begin
            dden_reg[k] <= den;
            dr_reg[k]   <= {num[k][31:0], 30'h0};
            dovf_reg[k] <= {3'b000, num[k]} >= {den, 3'b000};
        end
    end

    generate
        for (gl = 0; gl < 2; gl++)
        begin : g_dlane
            assign dd_w[gl][0]   = dden_reg[gl];
            assign dr_w[gl][0]   = dr_reg[gl];
            assign dq_w[gl][0]   = '0;
            assign dovf_w[gl][0] = dovf_reg[gl];
            for (gi = 0; gi < 33; gi++)
            begin : g_div
                qs_div_cell #(.I(32 - gi)) u_cell (
                    .clk     (clk),
                    .den_in  (dd_w[gl][gi]),
                    .r_in    (dr_w[gl][gi]),
                    .q_in    (dq_w[gl][gi]),
                    .ovf_in  (dovf_w[gl][gi]),
                    .den_out (dd_w[gl][gi+1]),
                    .r_out   (dr_w[gl][gi+1]),
                    .q_out   (dq_w[gl][gi+1]),
                    .ovf_out (dovf_w[gl][gi+1])
                );
            end
        end
    endgenerate

    // Weight selection: linear weights when the inputs are nearly parallel
    // or the sine of the angle came out non-positive.
    logic [31:0]        wq [0:1];
    logic [31:0]        w0s;
    logic [31:0]        w1s;
    logic               lin;
    logic signed [32:0] w0_reg;
    logic signed [32:0] w1_reg;
    logic               lin_reg;

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            wq[k] = (dovf_w[k][33] || dq_w[k][33] > {1'b0, qs_pkg::W_MAX})
                  ? qs_pkg::W_MAX : dq_w[k][33][31:0];
        end
        lin = side_reg[LQ-1].near || side_reg[LQ-1].deg;
        w0s = lin ? (32'(qs_pkg::ONE_W) - {1'b0, side_reg[LQ-1].t30}) : wq[0];
        w1s = lin ? {1'b0, side_reg[LQ-1].t30} : wq[1];
    end

    always_ff @(posedge clk)
    begin
        w0_reg  <= {1'b0, w0s};
        w1_reg  <= side_reg[LQ-1].negate ? -$signed({1'b0, w1s}) : $signed({1'b0, w1s});
        lin_reg <= lin;
    end

    // Per-component blend, then round half up and saturate.
    logic signed [48:0] pf [0:3];
    logic signed [48:0] pt [0:3];
    logic signed [49:0] acc_reg [0:3];
    logic signed [50:0] rnd [0:3];
    logic signed [20:0] rs [0:3];
    logic signed [15:0] res [0:3];
    logic signed [15:0] out_reg [0:3];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            pf[k]  = w0_reg * $signed(side_reg[LW-1].a[k]);
            pt[k]  = w1_reg * $signed(side_reg[LW-1].b[k]);
            rnd[k] = {acc_reg[k][49], acc_reg[k]} + 51'sh2000_0000;
            rs[k]  = rnd[k][50:30];
            if (rs[k] > 21'sd32767)
            begin
                res[k] = 16'sh7FFF;
            end
            else if (rs[k] < -21'sd32768)
            begin
                res[k] = 16'sh8000;
            end
            else
            begin
                res[k] = rs[k][15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            acc_reg[k] <= {pf[k][48], pf[k]} + {pt[k][48], pt[k]};
            out_reg[k] <= res[k];
        end
    end

    assign done  = v_reg[LO-1];
    assign out_x = out_reg[0];
    assign out_y = out_reg[1];
    assign out_z = out_reg[2];
    assign out_w = out_reg[3];

`include "assert_macros.svh"

    `QS_ASSERT_DELAY(a_latency, accept, LO, done)
    `QS_ASSERT_IMP(a_done_src, done, $past(accept, LO))
    `QS_ASSERT_IMP(a_w0_range, v_reg[LW-1], !w0_reg[32] && w0_reg <= 33'sh0_8000_0000)
    `QS_ASSERT_IMP(a_lin_sum, v_reg[LW-1] && lin_reg,
        (side_reg[LW-1].negate ? (w0_reg - w1_reg) : (w0_reg + w1_reg))
            == 33'(qs_pkg::ONE_W))

endmodule

/* hdl/qs_sqrt_cell.sv */
// One bit of the pipelined integer square root (one result bit per cell).
// Depends on nothing but its parameter K, the bit pair handled here.
module qs_sqrt_cell #(
    parameter int K = 0
) (
    input  logic        clk,
    input  logic [60:0] v_in,
    input  logic [61:0] r_in,
    output logic [60:0] v_out,
    output logic [61:0] r_out
);

    localparam logic [61:0] BIT = 62'(1) << (2 * K);

    logic [61:0] trial;
    logic [60:0] v_next;
    logic [61:0] r_next;

    always_comb
    begin
        trial = r_in + BIT;
        if ({1'b0, v_in} >= trial)
        begin
            v_next = v_in - trial[60:0];
            r_next = (r_in >> 1) + BIT;
        end
        else
        begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        v_out <= v_next;
        r_out <= r_next;
    end

endmodule

/* hdl/qs_vec_cell.sv */
// One iteration of the vectoring CORDIC that turns (x, y) into an angle.
// Depends on qs_pkg for the arctangent table.
module qs_vec_cell #(
    parameter int I = 0
) (
    input  logic               clk,
    input  logic signed [33:0] x_in,
    input  logic signed [33:0] y_in,
    input  logic signed [33:0] z_in,
    output logic signed [33:0] x_out,
    output logic signed [33:0] y_out,
    output logic signed [33:0] z_out
);

    localparam logic [31:0] ATAN = qs_pkg::atan_at(I);

    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] x_next;
    logic signed [33:0] y_next;
    logic signed [33:0] z_next;

    always_comb
    begin
        dx = y_in >>> I;
        dy = x_in >>> I;
        if (y_in > 0)
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + $signed({2'b00, ATAN});
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - $signed({2'b00, ATAN});
        end
    end

    always_ff @(posedge clk)
    begin
        x_out <= x_next;
        y_out <= y_next;
        z_out <= z_next;
    end

endmodule

/* hdl/qs_rot_cell.sv */
// One iteration of the rotation CORDIC that produces a gain-scaled sine.
// Depends on qs_pkg for the arctangent table.
module qs_rot_cell #(
    parameter int I = 0
) (
    input  logic               clk,
    input  logic signed [33:0] x_in,
    input  logic signed [33:0] y_in,
    input  logic signed [33:0] z_in,
    output logic signed [33:0] x_out,
    output logic signed [33:0] y_out,
    output logic signed [33:0] z_out
);

    localparam logic [31:0] ATAN = qs_pkg::atan_at(I);

    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] x_next;
    logic signed [33:0] y_next;
    logic signed [33:0] z_next;

    always_comb
    begin
        dx = y_in >>> I;
        dy = x_in >>> I;
        if (z_in >= 0)
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - $signed({2'b00, ATAN});
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + $signed({2'b00, ATAN});
        end
    end

    always_ff @(posedge clk)
    begin
        x_out <= x_next;
        y_out <= y_next;
        z_out <= z_next;
    end

endmodule

/* hdl/qs_div_cell.sv */
// One quotient bit of the pipelined restoring divider for the sine ratios.
// Depends on nothing but its parameter I, the quotient bit decided here.
module qs_div_cell #(
    parameter int I = 0
) (
    input  logic        clk,
    input  logic [31:0] den_in,
    input  logic [61:0] r_in,
    input  logic [32:0] q_in,
    input  logic        ovf_in,
    output logic [31:0] den_out,
    output logic [61:0] r_out,
    output logic [32:0] q_out,
    output logic        ovf_out
);

    logic [64:0] d;
    logic [61:0] r_next;
    logic [32:0] q_next;

    always_comb
    begin
        d      = 65'(den_in) << I;
        r_next = r_in;
        q_next = q_in;
        if ({3'b000, r_in} >= d)
        begin
            r_next    = r_in - d[61:0];
            q_next[I] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        den_out <= den_in;
        r_out   <= r_next;
        q_out   <= q_next;
        ovf_out <= ovf_in;
    end

endmodule
